### sv/pas_pkg.sv
// ============================================================================
// pas_pkg: shared definitions for the pneumatic actuator sequencer
// Status and action codes, register indexes, command characters, widths and
// register reset values.
// ============================================================================
package pas_pkg;

    // Field widths
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned ELAPSED_W  = 17;
    localparam int unsigned S_TDATA_W  = 16;
    localparam int unsigned M_TDATA_W  = 8;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TIMEOUT  = 3'd1,
        ST_CONFLICT = 3'd2,
        ST_UNSTABLE = 3'd3,
        ST_NOTCMD   = 3'd4
    } status_t;

    // Actions; also the index of the target sensor in the sense vector
    typedef enum logic [1:0] {
        ACT_Z_UP       = 2'd0,
        ACT_Z_DOWN     = 2'd1,
        ACT_GRIP_OPEN  = 2'd2,
        ACT_GRIP_CLOSE = 2'd3
    } action_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POST     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RECHECK  = 3'd4;

    // Register reset values
    localparam logic [15:0] TIMEOUT_RST = 16'd3000;
    localparam logic [7:0]  POLL_RST    = 8'd10;
    localparam logic [15:0] POST_RST    = 16'd100;
    localparam logic [9:0]  STABLE_RST  = 10'd100;
    localparam logic [9:0]  RECHECK_RST = 10'd50;

    // Command characters, upper case, plus lower-case bounds and the case offset
    localparam logic [7:0] CHAR_W     = 8'h57;  // 'W'
    localparam logic [7:0] CHAR_S     = 8'h53;  // 'S'
    localparam logic [7:0] CHAR_Q     = 8'h51;  // 'Q'
    localparam logic [7:0] CHAR_E     = 8'h45;  // 'E'
    localparam logic [7:0] CHAR_LC_A  = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_LC_Z  = 8'h7A;  // 'z'
    localparam logic [7:0] CASE_DELTA = 8'h20;  // 'a' - 'A'

endpackage

### sv/pneumatic_actuator_sequencer_unit.sv
// ============================================================================
// pneumatic_actuator_sequencer_unit: supervised solenoid moves
// Command characters start a move and a supervised wait on the target
// end-position sensor; 1 ms ticks drive polling, stability, timeout and the
// final confirming sample.
// ============================================================================
// Each result goes to a one-entry output register at the accept edge and shows
//   on the m_ side in the next cycle. Throughput: one item per cycle unless a
//   held result stalls s_tready; all state updates in a single pass per accept.
// Reset (aresetn low, synchronous): sequencer idle, drives off (gripper
//   closed, axis raised), no result pending, registers at their defaults.
module pneumatic_actuator_sequencer_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port
    input  logic                                cfg_wr_en,
    input  logic [pas_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pas_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // Input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] cmd_char, [8] grip_open_sense, [9] grip_closed_sense,
    // [10] z_up_sense, [11] z_down_sense, [15:12] zero
    input  logic [pas_pkg::S_TDATA_W-1:0]       s_tdata,
    // [0] op
    input  logic [0:0]                          s_tuser,
    // Result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [2:0] status, [4:3] action, [5] grip_solenoid, [6] z_solenoid, [7] zero
    output logic [pas_pkg::M_TDATA_W-1:0]       m_tdata
);

    localparam int unsigned EW = pas_pkg::ELAPSED_W;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_WAIT   = 2'd1,
        PH_SETTLE = 2'd2
    } phase_t;

    // Target sensor of an action; sense: 0 z up, 1 z down, 2 grip open, 3 grip closed
    function automatic logic target_of(input logic [1:0] act, input logic [3:0] sense);
        target_of = sense[act];
    endfunction

    // Both sensors of the moving axis active
    function automatic logic conflict_of(input logic [1:0] act, input logic [3:0] sense);
        if (act[1]) begin
            conflict_of = sense[2] & sense[3];
        end else begin
            conflict_of = sense[0] & sense[1];
        end
    endfunction

    // Configuration registers
    logic [15:0] timeout_reg;
    logic [7:0]  poll_reg;
    logic [15:0] post_reg;
    logic [9:0]  stable_reg;
    logic [9:0]  recheck_reg;

    // Sequencer state
    phase_t          phase_reg, phase_next;
    logic [1:0]      action_reg, action_next;
    logic [EW-1:0]   elapsed_reg, elapsed_next;
    logic [7:0]      poll_cnt_reg, poll_cnt_next;
    logic            seen_reg, seen_next;
    logic [EW-1:0]   since_reg, since_next;
    logic            grip_reg, grip_next;
    logic            z_reg, z_next;

    // Output register
    logic            m_valid_reg, m_valid_next;
    logic [2:0]      m_status_reg, m_status_next;
    logic [1:0]      m_action_reg, m_action_next;
    logic            m_grip_reg, m_grip_next;
    logic            m_z_reg, m_z_next;

    // Input decode
    logic            accept;
    logic            op;
    logic [7:0]      cmd_raw;
    logic [7:0]      cmd_uc;
    logic [3:0]      sense;
    logic            cmd_hit;
    logic [1:0]      cmd_act;
    logic [EW-1:0]   elapsed_inc;
    logic [EW-1:0]   total_delay;
    logic [7:0]      poll_dec;
    logic [7:0]      poll_reload;

    // Evaluation inputs
    logic            do_eval;
    logic [EW-1:0]   eval_el;
    logic            eval_seen;
    logic [EW-1:0]   eval_since;
    logic [1:0]      eval_act;
    logic [EW-1:0]   since_now;
    logic            res_valid;
    logic [2:0]      res_status;
    logic [1:0]      res_action;

    assign accept   = s_tvalid & s_tready;
    assign s_tready = ~m_valid_reg | m_tready;
    assign op       = s_tuser[0];
    assign cmd_raw  = s_tdata[7:0];
    // Sense vector reordered to action order
    assign sense    = {s_tdata[9], s_tdata[8], s_tdata[11], s_tdata[10]};

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_z_reg, m_grip_reg, m_action_reg, m_status_reg};

    // Command decode, lower case folded to upper
    always_comb begin
        if (cmd_raw >= pas_pkg::CHAR_LC_A && cmd_raw <= pas_pkg::CHAR_LC_Z) begin
            cmd_uc = cmd_raw - pas_pkg::CASE_DELTA;
        end else begin
            cmd_uc = cmd_raw;
        end
        cmd_hit = 1'b1;
        unique case (cmd_uc)
            pas_pkg::CHAR_W: cmd_act = pas_pkg::ACT_Z_UP;
            pas_pkg::CHAR_S: cmd_act = pas_pkg::ACT_Z_DOWN;
            pas_pkg::CHAR_Q: cmd_act = pas_pkg::ACT_GRIP_OPEN;
            pas_pkg::CHAR_E: cmd_act = pas_pkg::ACT_GRIP_CLOSE;
            default: begin
                cmd_act = pas_pkg::ACT_Z_UP;
                cmd_hit = 1'b0;
            end
        endcase
    end

    // Counter helpers
    assign elapsed_inc = (elapsed_reg == pas_pkg::ELAPSED_MAX) ? elapsed_reg
                                                               : elapsed_reg + 1'b1;
    assign total_delay = {1'b0, post_reg} + {{(EW-10){1'b0}}, recheck_reg};
    assign poll_dec    = (poll_cnt_reg != 8'd0) ? poll_cnt_reg - 8'd1 : 8'd0;
    assign poll_reload = (poll_reg != 8'd0) ? poll_reg : 8'd1;

    // Next-state logic: one pass per accepted item
    always_comb begin
        phase_next    = phase_reg;
        action_next   = action_reg;
        elapsed_next  = elapsed_reg;
        poll_cnt_next = poll_cnt_reg;
        seen_next     = seen_reg;
        since_next    = since_reg;
        grip_next     = grip_reg;
        z_next        = z_reg;

        res_valid  = 1'b0;
        res_status = pas_pkg::ST_OK;
        res_action = action_reg;

        do_eval    = 1'b0;
        eval_el    = elapsed_inc;
        eval_seen  = seen_reg;
        eval_since = since_reg;
        eval_act   = action_reg;
        since_now  = since_reg;

        if (accept) begin
            if (op) begin
                // Command character; ignored while busy
                if (phase_reg == PH_IDLE) begin
                    if (cmd_hit) begin
                        unique case (cmd_act)
                            pas_pkg::ACT_Z_UP:       z_next    = 1'b0;
                            pas_pkg::ACT_Z_DOWN:     z_next    = 1'b1;
                            pas_pkg::ACT_GRIP_OPEN:  grip_next = 1'b1;
                            pas_pkg::ACT_GRIP_CLOSE: grip_next = 1'b0;
                            default:                 z_next    = z_reg;
                        endcase
                        action_next  = cmd_act;
                        phase_next   = PH_WAIT;
                        elapsed_next = '0;
                        seen_next    = 1'b0;
                        since_next   = '0;
                        do_eval      = 1'b1;
                        eval_el      = '0;
                        eval_seen    = 1'b0;
                        eval_since   = '0;
                        eval_act     = cmd_act;
                    end else begin
                        res_valid  = 1'b1;
                        res_status = pas_pkg::ST_NOTCMD;
                        res_action = pas_pkg::ACT_Z_UP;
                    end
                end
            end else if (phase_reg != PH_IDLE) begin
                // Millisecond tick
                elapsed_next = elapsed_inc;
                if (phase_reg == PH_WAIT) begin
                    poll_cnt_next = poll_dec;
                    if (poll_dec == 8'd0) begin
                        do_eval = 1'b1;
                    end
                end else if (elapsed_inc >= total_delay) begin
                    phase_next = PH_IDLE;
                    res_valid  = 1'b1;
                    res_status = target_of(action_reg, sense) ? pas_pkg::ST_OK
                                                              : pas_pkg::ST_UNSTABLE;
                end
            end
        end

        // Poll evaluation: conflict, then stability, then timeout
        if (do_eval) begin
            res_action = eval_act;
            if (conflict_of(eval_act, sense)) begin
                phase_next = PH_IDLE;
                res_valid  = 1'b1;
                res_status = pas_pkg::ST_CONFLICT;
            end else begin
                if (target_of(eval_act, sense)) begin
                    since_now  = eval_seen ? eval_since : eval_el;
                    seen_next  = 1'b1;
                    since_next = since_now;
                end else begin
                    seen_next = 1'b0;
                end
                if (target_of(eval_act, sense) &&
                    (eval_el - since_now) >= {{(EW-10){1'b0}}, stable_reg}) begin
                    phase_next   = PH_SETTLE;
                    elapsed_next = '0;
                    if (total_delay == '0) begin
                        // No delay: final sample uses the same sensor bits
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res_status = pas_pkg::ST_OK;
                    end
                end else if (eval_el >= {1'b0, timeout_reg}) begin
                    phase_next = PH_IDLE;
                    res_valid  = 1'b1;
                    res_status = pas_pkg::ST_TIMEOUT;
                end else begin
                    poll_cnt_next = poll_reload;
                end
            end
        end
    end

    // Output register next values
    always_comb begin
        m_valid_next  = m_valid_reg & ~m_tready;
        m_status_next = m_status_reg;
        m_action_next = m_action_reg;
        m_grip_next   = m_grip_reg;
        m_z_next      = m_z_reg;
        if (res_valid) begin
            m_valid_next  = 1'b1;
            m_status_next = res_status;
            m_action_next = res_action;
            m_grip_next   = grip_next;
            m_z_next      = z_next;
        end
    end

    // State, configuration and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            action_reg   <= pas_pkg::ACT_Z_UP;
            elapsed_reg  <= '0;
            poll_cnt_reg <= '0;
            seen_reg     <= 1'b0;
            since_reg    <= '0;
            grip_reg     <= 1'b0;
            z_reg        <= 1'b0;
            m_valid_reg  <= 1'b0;
            timeout_reg  <= pas_pkg::TIMEOUT_RST;
            poll_reg     <= pas_pkg::POLL_RST;
            post_reg     <= pas_pkg::POST_RST;
            stable_reg   <= pas_pkg::STABLE_RST;
            recheck_reg  <= pas_pkg::RECHECK_RST;
        end else begin
            phase_reg    <= phase_next;
            action_reg   <= action_next;
            elapsed_reg  <= elapsed_next;
            poll_cnt_reg <= poll_cnt_next;
            seen_reg     <= seen_next;
            since_reg    <= since_next;
            grip_reg     <= grip_next;
            z_reg        <= z_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    pas_pkg::REG_TIMEOUT: timeout_reg <= cfg_wdata;
                    pas_pkg::REG_POLL:    poll_reg    <= cfg_wdata[7:0];
                    pas_pkg::REG_POST:    post_reg    <= cfg_wdata;
                    pas_pkg::REG_STABLE:  stable_reg  <= cfg_wdata[9:0];
                    pas_pkg::REG_RECHECK: recheck_reg <= cfg_wdata[9:0];
                    default: begin
                    end
                endcase
            end
        end
        m_status_reg <= m_status_next;
        m_action_reg <= m_action_next;
        m_grip_reg   <= m_grip_next;
        m_z_reg      <= m_z_next;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // While waiting the poll counter is always armed
    a_poll_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_WAIT |-> poll_cnt_reg != 8'd0)
        else $error("poll counter empty while waiting");

    // Stability start never lies ahead of elapsed time
    a_since_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_WAIT && seen_reg) |-> since_reg <= elapsed_reg)
        else $error("stable start after elapsed time");

    // A move result always leaves the sequencer idle
    a_result_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_status != pas_pkg::ST_NOTCMD) |=> phase_reg == PH_IDLE)
        else $error("move result without returning to idle");

    // Unknown command reports the zero action
    a_notcmd_action: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == pas_pkg::ST_NOTCMD) |-> m_action_reg == 2'd0)
        else $error("not-a-command result with nonzero action");

    // Input stalls only behind a pending result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_valid_reg && !m_tready))
        else $error("input stalled without a pending result");

endmodule
